@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define SINK_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SINK_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SINK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/sink_pkg.sv @@
// ---------------------------------------------------------------------------
// sink_pkg
// Types, constants and elaboration helpers of the sorted insert unit.
// ---------------------------------------------------------------------------
package sink_pkg;

   localparam int unsigned CAPACITY = 1024;
   localparam int unsigned KEY_W    = 31;
   localparam int unsigned TAG_W    = 31;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned LEAF_W   = TAG_W + 1;   // {duplicate, tag}
   localparam int unsigned FANIN    = 32;

   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED_KEY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_TAG = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   localparam logic [KEY_W-1:0] SEED_KEY_RST = 31'd1000000000;
   localparam logic [TAG_W-1:0] SEED_TAG_RST = 31'd1;

   // nodes on a tree level; level 0 is the row of cells
   function automatic int unsigned tree_nodes(input int unsigned level);
      int unsigned n;
      n = CAPACITY;
      for (int unsigned i = 0; i < level; i++) begin
         n = (n + FANIN - 1) / FANIN;
      end
      return n;
   endfunction

   function automatic int unsigned tree_levels();
      int unsigned n;
      int unsigned l;
      n = CAPACITY;
      l = 0;
      while (n > 1) begin
         n = (n + FANIN - 1) / FANIN;
         l++;
      end
      return l;
   endfunction

   // position of a level's first node in the flat register array (levels from 1)
   function automatic int unsigned tree_offset(input int unsigned level);
      int unsigned s;
      s = 0;
      for (int unsigned k = 1; k < level; k++) begin
         s = s + tree_nodes(k);
      end
      return s;
   endfunction

   localparam int unsigned TREE_LEVELS = tree_levels();
   localparam int unsigned TREE_TOTAL  = tree_offset(TREE_LEVELS + 1);
   localparam int unsigned CNT_W       = $clog2(TREE_LEVELS + 1);

   typedef struct packed {
      logic             valid;
      logic             lt;     // valid and key below the pending key
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } slot_type;

   typedef struct packed {
      logic             reseed;
      logic             commit;
      logic [KEY_W-1:0] seed_key;
      logic [TAG_W-1:0] seed_tag;
   } cell_ctrl_type;

endpackage

@@ design/sink_cell.sv @@
// ---------------------------------------------------------------------------
// sink_cell
// One table slot: compares against the pending key, picks the nearest tag
// when it is the lower neighbour, and shifts right on an insert.
// ---------------------------------------------------------------------------
module sink_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             first,
   input  sink_pkg::cell_ctrl_type          ctrl,
   input  logic [sink_pkg::KEY_W-1:0]       new_key,
   input  logic [sink_pkg::TAG_W-1:0]       new_tag,
   input  sink_pkg::slot_type               left,
   input  sink_pkg::slot_type               right,
   output sink_pkg::slot_type               slot,
   output logic                             hit,
   output logic [sink_pkg::LEAF_W-1:0]      leaf
);

   logic                       valid_ff, valid_in;
   logic [sink_pkg::KEY_W-1:0] key_ff, key_in;
   logic [sink_pkg::TAG_W-1:0] tag_ff, tag_in;

   logic                       lt_w, eq_w, lower_w, take_right_w;
   logic [sink_pkg::KEY_W:0]   sum_w;
   logic [sink_pkg::TAG_W-1:0] pick_w;

   assign lt_w = valid_ff && (key_ff < new_key);
   assign eq_w = valid_ff && (key_ff == new_key);

   // lower neighbour: last slot below the key
   assign lower_w = lt_w && !right.lt;
   // upper distance strictly smaller: k + k_right < 2 * key
   assign sum_w        = {1'b0, key_ff} + {1'b0, right.key};
   assign take_right_w = right.valid && (sum_w < {new_key, 1'b0});
   assign pick_w       = (lower_w && take_right_w) ? right.tag : tag_ff;

   // head slot answers alone when nothing lies below the key
   assign hit  = lower_w || (first && !lt_w);
   assign leaf = {eq_w, hit ? pick_w : {sink_pkg::TAG_W{1'b0}}};

   assign slot.valid = valid_ff;
   assign slot.lt    = lt_w;
   assign slot.key   = key_ff;
   assign slot.tag   = tag_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      if (ctrl.reseed) begin
         valid_in = first;
         key_in   = ctrl.seed_key;
         tag_in   = ctrl.seed_tag;
      end else if (ctrl.commit && !lt_w) begin
         if (first || left.lt) begin
            valid_in = 1'b1;
            key_in   = new_key;
            tag_in   = new_tag;
         end else begin
            valid_in = left.valid;
            key_in   = left.key;
            tag_in   = left.tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= first;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

@@ design/sink_or_tree.sv @@
// ---------------------------------------------------------------------------
// sink_or_tree
// Registered OR reduction of the per-slot leaves, with a register on each level.
// ---------------------------------------------------------------------------
module sink_or_tree (
   input  logic                        clock,
   input  logic [sink_pkg::LEAF_W-1:0] leaf [sink_pkg::CAPACITY],
   output logic [sink_pkg::LEAF_W-1:0] root
);

   logic [sink_pkg::LEAF_W-1:0] node_ff [sink_pkg::TREE_TOTAL];

   for (genvar l = 1; l <= sink_pkg::TREE_LEVELS; l++) begin : g_level
      localparam int unsigned NI = sink_pkg::tree_nodes(l - 1);
      localparam int unsigned NO = sink_pkg::tree_nodes(l);
      localparam int unsigned OO = sink_pkg::tree_offset(l);

      for (genvar n = 0; n < NO; n++) begin : g_node
         logic [sink_pkg::LEAF_W-1:0] kids_w [sink_pkg::FANIN];
         logic [sink_pkg::LEAF_W-1:0] or_w;

         for (genvar j = 0; j < sink_pkg::FANIN; j++) begin : g_kid
            localparam int unsigned IDX = n * sink_pkg::FANIN + j;
            if (IDX >= NI) begin : g_pad
               assign kids_w[j] = '0;
            end else if (l == 1) begin : g_leaf
               assign kids_w[j] = leaf[IDX];
            end else begin : g_inner
               localparam int unsigned OI = sink_pkg::tree_offset(l - 1);
               assign kids_w[j] = node_ff[OI + IDX];
            end
         end

         always_comb begin
            or_w = '0;
            for (int j = 0; j < sink_pkg::FANIN; j++) begin
               or_w = or_w | kids_w[j];
            end
         end

         always_ff @(posedge clock) begin
            node_ff[OO + n] <= or_w;
         end
      end
   end

   assign root = node_ff[sink_pkg::tree_offset(sink_pkg::TREE_LEVELS)];

endmodule

@@ design/sorted_insert_nearest_key_unit.sv @@
// ---------------------------------------------------------------------------
// sorted_insert_nearest_key_unit
// Sorted (key, tag) table with insert and nearest-key lookup.
//
// The table is a row of CAPACITY slots kept in ascending key order; after
// reset, and after any write of seed_key or seed_tag, it holds just the seed
// entry. Each request transaction carries a key and a tag. Every slot compares
// its key against the request key at once; the slot just below the key
// settles locally between itself and its right neighbour (smaller key wins a
// tie), and a registered 32-way OR tree gathers that tag and the duplicate
// flag. Once the tree has settled the slots shift right by one place to open
// the gap and the new pair drops in, both on the same edge. A transaction is
// registered on acceptance, the slots compare against it, the OR tree levels
// register the result in turn, and once the root holds it and the response
// register is free the response is loaded and the insert commits; the next
// request is taken in that cycle, so none is taken while one is pending. A
// duplicate key gives status 1 and a full table status 2, both with tag 0 and
// no insert. No clearing pass: reseeding goes through the per-slot valid bits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_insert_nearest_key_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request: [30:0] member_tag, [61:31] member_key, [63:62] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sink_pkg::REQ_DATA_W-1:0]     req_tdata,
   // response: [30:0] nearest_tag, [32:31] status, [39:33] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sink_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register writes: index 0 seed_key, 1 seed_tag
   input  logic                                csr_we,
   input  logic [sink_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sink_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned CAP = sink_pkg::CAPACITY;

   // seed registers
   logic [sink_pkg::KEY_W-1:0] seed_key_ff, seed_key_in;
   logic [sink_pkg::TAG_W-1:0] seed_tag_ff, seed_tag_in;

   // pending transaction
   logic [sink_pkg::KEY_W-1:0] item_key_ff;
   logic [sink_pkg::TAG_W-1:0] item_tag_ff;
   logic                       busy_ff, busy_in;
   logic [sink_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sink_pkg::TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [sink_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic accept_w, done_w, out_free_w, commit_w, dup_w, full_w;

   sink_pkg::cell_ctrl_type      ctrl_w;
   sink_pkg::slot_type           slot_w [CAP];
   logic [sink_pkg::LEAF_W-1:0]  leaf_w [CAP];
   logic [sink_pkg::LEAF_W-1:0]  root_w;
   logic [CAP-1:0]               hit_w;
   logic [CAP-1:0]               valid_vec_w;

   // -------------------------------------------------------------------
   // handshake and sequencing
   // -------------------------------------------------------------------
   assign done_w     = busy_ff && (cnt_ff == sink_pkg::TREE_LEVELS[sink_pkg::CNT_W-1:0]);
   assign out_free_w = !rsp_valid_ff || rsp_tready;
   assign commit_w   = done_w && out_free_w;

   // a new transaction may land on the same edge the last one completes
   assign req_tready = !busy_ff || commit_w;
   assign accept_w   = req_tvalid && req_tready;

   assign dup_w  = root_w[sink_pkg::LEAF_W-1];
   assign full_w = slot_w[CAP-1].valid;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (accept_w) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (commit_w) begin
         busy_in = 1'b0;
      end else if (busy_ff && !done_w) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // -------------------------------------------------------------------
   // seed registers; a write of either reseeds the table
   // -------------------------------------------------------------------
   always_comb begin
      seed_key_in = seed_key_ff;
      seed_tag_in = seed_tag_ff;
      if (reset) begin
         seed_key_in = sink_pkg::SEED_KEY_RST;
         seed_tag_in = sink_pkg::SEED_TAG_RST;
      end else if (csr_we) begin
         case (csr_index)
            sink_pkg::CSR_SEED_KEY: seed_key_in = csr_wdata;
            sink_pkg::CSR_SEED_TAG: seed_tag_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign ctrl_w.reseed   = reset || csr_we;
   assign ctrl_w.commit   = commit_w && !dup_w && !full_w;
   assign ctrl_w.seed_key = seed_key_in;
   assign ctrl_w.seed_tag = seed_tag_in;

   // -------------------------------------------------------------------
   // response register
   // -------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      if (commit_w) begin
         rsp_valid_in = 1'b1;
         if (dup_w) begin
            rsp_tag_in    = '0;
            rsp_status_in = sink_pkg::STATUS_DUPLICATE;
         end else if (full_w) begin
            rsp_tag_in    = '0;
            rsp_status_in = sink_pkg::STATUS_FULL;
         end else begin
            rsp_tag_in    = root_w[sink_pkg::TAG_W-1:0];
            rsp_status_in = sink_pkg::STATUS_INSERTED;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sink_pkg::RSP_DATA_W - sink_pkg::TAG_W - sink_pkg::STATUS_W){1'b0}},
                        rsp_status_ff, rsp_tag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seed_key_ff   <= seed_key_in;
      seed_tag_ff   <= seed_tag_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
      if (accept_w) begin
         item_tag_ff <= req_tdata[sink_pkg::TAG_W-1:0];
         item_key_ff <= req_tdata[sink_pkg::TAG_W +: sink_pkg::KEY_W];
      end
   end

   // -------------------------------------------------------------------
   // row of slots
   // -------------------------------------------------------------------
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      sink_pkg::slot_type left_w, right_w;

      if (i == 0) begin : g_head
         assign left_w = '0;
      end else begin : g_body
         assign left_w = slot_w[i-1];
      end

      if (i == CAP - 1) begin : g_tail
         assign right_w = '0;
      end else begin : g_mid
         assign right_w = slot_w[i+1];
      end

      sink_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .first   (i == 0),
         .ctrl    (ctrl_w),
         .new_key (item_key_ff),
         .new_tag (item_tag_ff),
         .left    (left_w),
         .right   (right_w),
         .slot    (slot_w[i]),
         .hit     (hit_w[i]),
         .leaf    (leaf_w[i])
      );

      assign valid_vec_w[i] = slot_w[i].valid;
   end

   sink_or_tree u_tree (
      .clock (clock),
      .leaf  (leaf_w),
      .root  (root_w)
   );

   // -------------------------------------------------------------------
   // checks
   // -------------------------------------------------------------------
   // occupied slots always form a run from slot 0
   `SINK_ASSERT(a_valid_prefix, ((valid_vec_w & (valid_vec_w + 1'b1)) == '0) && valid_vec_w[0], "occupied slots not contiguous from slot 0")
   // at most one slot claims the nearest tag
   `SINK_ASSERT_IMP(a_single_hit, busy_ff, $onehot0(hit_w), "more than one slot claims the nearest tag")
   // an insert adds exactly one entry
   `SINK_ASSERT_NEXT(a_insert_grows, ctrl_w.commit && !csr_we, $countones(valid_vec_w) == $past($countones(valid_vec_w)) + 1, "insert did not grow the table by one")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_insert_nearest_key_unit. A sorted shadow
// table predicts each response (nearest tag, status) as requests are
// accepted; responses are checked in order. Covers the reset seed, seed
// register writes, sparse and dense keys, ties, duplicates and a full table,
// with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module tb;

   localparam int unsigned LATENCY        = sink_pkg::TREE_LEVELS + 1;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned IDX_W          = $clog2(sink_pkg::CAPACITY);
   localparam logic [sink_pkg::KEY_W-1:0] KEY_MAX = '1;
   localparam logic [sink_pkg::TAG_W-1:0] TAG_MAX = '1;

   // entry count, 0 .. CAPACITY
   typedef logic [IDX_W:0] count_type;

   localparam count_type CAP_COUNT = sink_pkg::CAPACITY[IDX_W:0];

   typedef struct {
      logic [sink_pkg::TAG_W-1:0]    tag;
      logic [sink_pkg::STATUS_W-1:0] status;
   } lookup_result_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [sink_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [sink_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we     = 1'b0;
   logic [sink_pkg::CSR_IDX_W-1:0]  csr_index  = sink_pkg::CSR_SEED_KEY;
   logic [sink_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // shadow of the unit: sorted table plus seed registers
   logic [sink_pkg::KEY_W-1:0] key_tab [sink_pkg::CAPACITY];
   logic [sink_pkg::TAG_W-1:0] tag_tab [sink_pkg::CAPACITY];
   count_type                  fill;
   logic [sink_pkg::KEY_W-1:0] seed_key_r;
   logic [sink_pkg::TAG_W-1:0] seed_tag_r;

   lookup_result_type expected_lookups[$];
   int unsigned       mismatch_count = 0;

   // idling state: each burst is calm (no gaps) or gappy, chosen at random
   int unsigned req_burst = 0;
   bit          req_calm  = 1'b0;
   int unsigned rsp_burst = 0;
   bit          rsp_calm  = 1'b0;
   int unsigned stall_left = 0;

   sorted_insert_nearest_key_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [30:0] member_tag, [61:31] member_key, [63:62] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [30:0] nearest_tag, [32:31] status, [39:33] zero
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int unsigned gap_length(input bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // random values cut to field width
   function automatic logic [sink_pkg::KEY_W-1:0] rand_key();
      logic [31:0] r;
      r = $urandom;
      return r[sink_pkg::KEY_W-1:0];
   endfunction

   function automatic logic [sink_pkg::TAG_W-1:0] rand_tag();
      logic [31:0] r;
      r = $urandom;
      return r[sink_pkg::TAG_W-1:0];
   endfunction

   function automatic logic [sink_pkg::KEY_W-1:0] rand_key_in(input int unsigned lo,
                                                             input int unsigned hi);
      logic [31:0] r;
      r = $urandom_range(hi, lo);
      return r[sink_pkg::KEY_W-1:0];
   endfunction

   // a key already held in the shadow table
   function automatic logic [sink_pkg::KEY_W-1:0] stored_key();
      logic [31:0] r;
      r = $urandom_range(0, fill - 1);
      return key_tab[r[IDX_W-1:0]];
   endfunction

   // table holds only the seed entry
   function automatic void reseed_table();
      fill       = {{IDX_W{1'b0}}, 1'b1};
      key_tab[0] = seed_key_r;
      tag_tab[0] = seed_tag_r;
   endfunction

   // sorted insert with nearest-key lookup; lookup sees the table before the insert
   function automatic lookup_result_type insert_member(
      input logic [sink_pkg::TAG_W-1:0] tag,
      input logic [sink_pkg::KEY_W-1:0] key);
      count_type                  pos;
      count_type                  i;
      logic [IDX_W-1:0]           at;
      logic [IDX_W-1:0]           lo;
      logic [sink_pkg::KEY_W-1:0] d_lo;
      logic [sink_pkg::KEY_W-1:0] d_hi;
      lookup_result_type          r;
      pos   = '0;
      d_lo  = '0;
      r.tag = '0;
      while (pos < fill && key_tab[pos[IDX_W-1:0]] < key) pos++;
      at = pos[IDX_W-1:0];
      if (pos < fill && key_tab[at] == key) begin
         r.status = sink_pkg::STATUS_DUPLICATE;
      end else if (fill >= CAP_COUNT) begin
         // full only checked once the key is known to be new
         r.status = sink_pkg::STATUS_FULL;
      end else begin
         r.status = sink_pkg::STATUS_INSERTED;
         if (pos != '0) begin
            lo    = at - 1'b1;
            d_lo  = key - key_tab[lo];
            r.tag = tag_tab[lo];
         end
         // upper neighbour wins only when strictly nearer
         if (pos < fill) begin
            d_hi = key_tab[at] - key;
            if (pos == '0 || d_hi < d_lo) r.tag = tag_tab[at];
         end
         for (i = fill; i > pos; i--) begin
            key_tab[i[IDX_W-1:0]] = key_tab[i[IDX_W-1:0] - 1'b1];
            tag_tab[i[IDX_W-1:0]] = tag_tab[i[IDX_W-1:0] - 1'b1];
         end
         key_tab[at] = key;
         tag_tab[at] = tag;
         fill++;
      end
      return r;
   endfunction

   // one request transaction; valid is left high on return so back-to-back
   // items never lower and raise it in the same step
   task automatic send_member(input logic [sink_pkg::TAG_W-1:0] tag,
                              input logic [sink_pkg::KEY_W-1:0] key);
      int unsigned gap;
      if (req_burst == 0) begin
         req_burst = $urandom_range(10, 60);
         req_calm  = ($urandom_range(0, 3) == 0);
      end
      req_burst--;
      gap = gap_length(req_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, key, tag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_lookups.push_back(insert_member(tag, key));
   endtask

   // stop sending, wait for every response, then let the pipe empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // register write; the unit reseeds its table on any seed write
   task automatic write_reg(input logic [sink_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [sink_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         sink_pkg::CSR_SEED_KEY: seed_key_r = value;
         sink_pkg::CSR_SEED_TAG: seed_tag_r = value;
         default: ;
      endcase
      reseed_table();
   endtask

   task automatic reseed_with(input logic [sink_pkg::KEY_W-1:0] key,
                              input logic [sink_pkg::TAG_W-1:0] tag);
      settle();
      write_reg(sink_pkg::CSR_SEED_KEY, key);
      write_reg(sink_pkg::CSR_SEED_TAG, tag);
   endtask

   // seed from reset: key 1000000000, tag 1; extremes, ties, near-misses
   task automatic test_reset_seed();
      send_member(TAG_MAX, 31'd1000000000);        // duplicate of the seed
      send_member('0, KEY_MAX);                    // top key, lower neighbour only
      send_member(31'h5555_5555, '0);              // key zero, no lower neighbour
      send_member(31'h2AAA_AAAA, 31'd1);           // lower neighbour at distance 1
      send_member(31'd11, 31'd500000000);          // lower nearer by one
      send_member(31'd12, 31'd750000000);          // exact tie, smaller key wins
      send_member(31'd13, 31'd750000001);
      send_member(31'd14, 31'd999999999);          // upper strictly nearer
      send_member(31'd15, 31'h7FFF_FFFE);          // upper neighbour is the top key
      send_member(31'd16, '0);                     // duplicate at the bottom
      send_member(31'd17, KEY_MAX);                // duplicate at the top
   endtask

   // each seed write reseeds; extreme seed values
   task automatic test_seed_registers();
      settle();
      write_reg(sink_pkg::CSR_SEED_KEY, KEY_MAX);
      send_member(31'd5, 31'h7FFF_FFFE);
      send_member(31'd6, KEY_MAX);
      settle();
      write_reg(sink_pkg::CSR_SEED_TAG, '0);
      send_member(31'd7, 31'h7FFF_FFFE);           // gone after reseed, so no duplicate
      reseed_with(31'd1, TAG_MAX);
      send_member(31'd3, '0);
      send_member(31'd8, 31'd1);
      send_member(31'd4, 31'd2);
      settle();
      write_reg(sink_pkg::CSR_SEED_KEY, '0);       // seed key zero, the lowest key
      send_member(31'd9, '0);
      send_member(31'd10, KEY_MAX);
   endtask

   // full-range keys, some repeats of stored keys
   task automatic test_sparse_keys();
      logic [sink_pkg::KEY_W-1:0] key;
      logic [sink_pkg::TAG_W-1:0] tag;
      for (int c = 0; c < 4; c++) begin
         reseed_with(rand_key_in(1, 32'h7FFF_FFFF), rand_tag());
         for (int n = 0; n < 100; n++) begin
            key = rand_key();
            tag = rand_tag();
            if ($urandom_range(0, 4) == 0) key = stored_key();
            send_member(tag, key);
         end
      end
   endtask

   // keys packed around the seed: frequent ties and duplicates
   task automatic test_dense_keys();
      logic [31:0] centre;
      logic [31:0] pick;
      for (int c = 0; c < 4; c++) begin
         centre = $urandom_range(32'h7FFF_FF00, 200);
         reseed_with(centre[sink_pkg::KEY_W-1:0], rand_tag());
         for (int n = 0; n < 100; n++) begin
            pick = centre - 32'd128 + $urandom_range(256, 0);
            send_member(rand_tag(), pick[sink_pkg::KEY_W-1:0]);
         end
      end
   endtask

   // fill the table, then hit it with duplicates and new keys, then reseed
   task automatic test_fill_to_capacity();
      logic [sink_pkg::KEY_W-1:0] key;
      reseed_with(rand_key_in(1, 32'h7FFF_FFFF), rand_tag());
      while (fill < CAP_COUNT) send_member(rand_tag(), rand_key());
      for (int n = 0; n < 40; n++) begin
         key = rand_key();
         if ($urandom_range(0, 1) == 0) key = stored_key();
         send_member(rand_tag(), key);
      end
      settle();
      write_reg(sink_pkg::CSR_SEED_TAG, rand_tag());
      send_member(rand_tag(), rand_key());
   endtask

   // response side: check each transaction, drive random stalls
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lookups.size() == 0) begin
            $display("%0t: unexpected response tag %0d status %0d", $time,
                     rsp_tdata[30:0], rsp_tdata[32:31]);
            mismatch_count++;
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_tdata[30:0] !== want.tag) begin
               $display("%0t: nearest_tag expected %0d actual %0d", $time,
                        want.tag, rsp_tdata[30:0]);
               mismatch_count++;
            end
            if (rsp_tdata[32:31] !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_tdata[32:31]);
               mismatch_count++;
            end
         end
      end
      if (rsp_burst == 0) begin
         rsp_burst = $urandom_range(10, 60);
         rsp_calm  = ($urandom_range(0, 3) == 0);
      end
      rsp_burst--;
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = gap_length(rsp_calm);
      end
   end

   // watchdog: too long with no transaction on either channel
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      seed_key_r = sink_pkg::SEED_KEY_RST;
      seed_tag_r = sink_pkg::SEED_TAG_RST;
      reseed_table();
      test_reset_seed();
      test_seed_registers();
      test_sparse_keys();
      test_dense_keys();
      test_fill_to_capacity();
      settle();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
